[hw/rtl/tun_pkg.sv]
// Shared constants for the triangle unit normal block.
package tun_pkg;
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;
endpackage

[hw/rtl/tun_lane.sv]
// One normal component: bit-serial pipelined search for round(m * 2^F / sqrt(S)).
module tun_lane #(
  parameter int SW        = 70,
  parameter int RW        = 100,
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic [SW-1:0]        s_in,
  input  logic [RW-1:0]        r_in,
  output logic [FRAC_BITS:0]   q_out
);
  localparam int QW = FRAC_BITS + 1;
  localparam int XW = SW + 2 * FRAC_BITS + 5;

  // d tracks (2q-1)^2 * S, e tracks (2q-1) * S
  logic signed [XW-1:0] d_r [1:QW];
  logic signed [XW-1:0] e_r [1:QW];
  logic [SW-1:0]        s_r [1:QW];
  logic [RW-1:0]        r_r [1:QW];
  logic [QW-1:0]        q_r [1:QW];

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int K = QW - j;
    logic signed [XW-1:0] d_in, e_in, s_x, d_nxt;
    logic [SW-1:0]        s_cur;
    logic [RW-1:0]        r_cur;
    logic [QW-1:0]        q_in;
    logic                 ok;

    if (j == 1) begin : g_first
      assign s_cur = s_in;
      assign r_cur = r_in;
      assign d_in  = XW'(s_in);
      assign e_in  = -XW'(s_in);
      assign q_in  = '0;
    end else begin : g_next
      assign s_cur = s_r[j-1];
      assign r_cur = r_r[j-1];
      assign d_in  = d_r[j-1];
      assign e_in  = e_r[j-1];
      assign q_in  = q_r[j-1];
    end

    always_comb begin
      s_x   = XW'(s_cur);
      d_nxt = d_in + (e_in <<< (K + 2)) + (s_x <<< (2 * K + 2));
      ok    = d_nxt <= signed'(XW'(r_cur));
    end

    always_ff @(posedge clk) begin
      s_r[j] <= s_cur;
      r_r[j] <= r_cur;
      d_r[j] <= ok ? d_nxt : d_in;
      e_r[j] <= ok ? e_in + (s_x <<< (K + 1)) : e_in;
      q_r[j] <= ok ? (q_in | (QW'(1) << K)) : q_in;
    end
  end

  assign q_out = q_r[QW];
endmodule

[hw/rtl/triangle_unit_normal.sv]
// Triangle unit normal: normalized cross product (B-A) x (C-B) in signed Q1.FRAC_BITS.
//
// Usage: present vertices A, B, C on in_* and pulse start. busy is always low,
// so a transaction is taken on every cycle that start is high. Each transaction
// yields exactly one result, shown on out_* for one cycle with out_valid high.
// Throughput is one triangle per clock. Registered stages form the edge
// differences, the products, the cross product, the partial squares, the
// squares and the squared length; a chain of lane stages then resolves one
// result bit each per component; a final register applies sign and the degenerate
// case. A zero cross product gives a zero normal with out_degenerate set.
// Reset (synchronous, rst_n low) clears all valid bits; items in flight are
// dropped. The receiver cannot stall: results must be taken when shown.
module triangle_unit_normal #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tun_pkg::IN_W-1:0]   in_ax, in_ay, in_az,
  input  logic [tun_pkg::IN_W-1:0]   in_bx, in_by, in_bz,
  input  logic [tun_pkg::IN_W-1:0]   in_cx, in_cy, in_cz,
  output logic                       out_valid,
  output logic [tun_pkg::OUT_W-1:0]  out_nx, out_ny, out_nz,
  output logic                       out_degenerate
);
  localparam int CW   = COORD_WIDTH;
  localparam int XINW = (CW > tun_pkg::IN_W) ? CW : tun_pkg::IN_W;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int MW   = PW;
  localparam int HW   = (MW + 1) / 2;
  localparam int LW   = MW - HW;
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;
  localparam int RW   = SQW + 2 * FRAC_BITS + 2;
  localparam int QW   = FRAC_BITS + 1;
  localparam int VW   = (QW + 1 > tun_pkg::OUT_W) ? QW + 1 : tun_pkg::OUT_W;
  localparam int PRE  = 6;
  localparam int DEP  = PRE + QW;

  logic [XINW-1:0] raw [9];
  logic signed [CW-1:0] co [9];

  always_comb begin
    raw[0] = XINW'(in_ax); raw[1] = XINW'(in_ay); raw[2] = XINW'(in_az);
    raw[3] = XINW'(in_bx); raw[4] = XINW'(in_by); raw[5] = XINW'(in_bz);
    raw[6] = XINW'(in_cx); raw[7] = XINW'(in_cy); raw[8] = XINW'(in_cz);
    for (int i = 0; i < 9; i++) co[i] = signed'(raw[i][CW-1:0]);
  end

  assign busy = 1'b0;

  logic [DEP:1] vld_r;
  logic         take;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[DEP-1:1], take};
      out_valid <= vld_r[DEP];
    end
  end

  // stage 1: edge vectors
  logic signed [DW-1:0] u_r [3];
  logic signed [DW-1:0] v_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u_r[i] <= DW'(co[3+i]) - DW'(co[i]);
      v_r[i] <= DW'(co[6+i]) - DW'(co[3+i]);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] p_r [6];
  always_ff @(posedge clk) begin
    p_r[0] <= PW'(u_r[1]) * PW'(v_r[2]);
    p_r[1] <= PW'(u_r[2]) * PW'(v_r[1]);
    p_r[2] <= PW'(u_r[2]) * PW'(v_r[0]);
    p_r[3] <= PW'(u_r[0]) * PW'(v_r[2]);
    p_r[4] <= PW'(u_r[0]) * PW'(v_r[1]);
    p_r[5] <= PW'(u_r[1]) * PW'(v_r[0]);
  end

  // stage 3: cross product
  logic signed [NW-1:0] n_r [3];
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) n_r[i] <= NW'(p_r[2*i]) - NW'(p_r[2*i+1]);
  end

  // stage 4: magnitude split into partial squares
  logic [NW-1:0]   mag_w [3];
  logic [2*LW-1:0] hh_r [3];
  logic [LW+HW-1:0] hl_r [3];
  logic [2*HW-1:0] ll_r [3];
  logic [2:0]      neg4_r;
  always_comb begin
    for (int i = 0; i < 3; i++) mag_w[i] = n_r[i][NW-1] ? NW'(-n_r[i]) : NW'(n_r[i]);
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      hh_r[i] <= (2*LW)'(mag_w[i][MW-1:HW]) * (2*LW)'(mag_w[i][MW-1:HW]);
      hl_r[i] <= (LW+HW)'(mag_w[i][MW-1:HW]) * (LW+HW)'(mag_w[i][HW-1:0]);
      ll_r[i] <= (2*HW)'(mag_w[i][HW-1:0]) * (2*HW)'(mag_w[i][HW-1:0]);
      neg4_r[i] <= n_r[i][NW-1];
    end
  end

  // stage 5: squares
  logic [SQW-1:0] sq_r [3];
  logic [2:0]     neg5_r;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= (SQW'(hh_r[i]) << (2 * HW)) + (SQW'(hl_r[i]) << (HW + 1)) + SQW'(ll_r[i]);
    end
    neg5_r <= neg4_r;
  end

  // stage 6: squared length and per-lane bounds
  logic [SW-1:0] sum_w;
  logic [SW-1:0] s_r;
  logic [RW-1:0] r_r [3];
  logic [2:0]    neg6_r;
  logic          deg6_r;
  assign sum_w = SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
  always_ff @(posedge clk) begin
    s_r    <= sum_w;
    deg6_r <= sum_w == '0;
    neg6_r <= neg5_r;
    for (int i = 0; i < 3; i++) r_r[i] <= RW'(sq_r[i]) << (2 * FRAC_BITS + 2);
  end

  logic [QW-1:0] q_w [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_lane #(.SW(SW), .RW(RW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .s_in  (s_r),
      .r_in  (r_r[i]),
      .q_out (q_w[i])
    );
  end

  logic [2:0] neg_q_r [1:QW];
  logic       deg_q_r [1:QW];
  always_ff @(posedge clk) begin
    neg_q_r[1] <= neg6_r;
    deg_q_r[1] <= deg6_r;
    for (int j = 2; j <= QW; j++) begin
      neg_q_r[j] <= neg_q_r[j-1];
      deg_q_r[j] <= deg_q_r[j-1];
    end
  end

  logic [VW-1:0] comp_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      comp_w[i] = neg_q_r[QW][i] ? VW'(-VW'(q_w[i])) : VW'(q_w[i]);
      if (deg_q_r[QW]) comp_w[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    out_nx         <= comp_w[0][tun_pkg::OUT_W-1:0];
    out_ny         <= comp_w[1][tun_pkg::OUT_W-1:0];
    out_nz         <= comp_w[2][tun_pkg::OUT_W-1:0];
    out_degenerate <= deg_q_r[QW];
  end

  a_busy_low : assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");
  a_deg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
    else $error("degenerate result not zero");
  a_nondeg_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |-> out_nx != '0 || out_ny != '0 || out_nz != '0)
    else $error("nondegenerate result is zero");
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[DEP] |=> out_valid)
    else $error("result lost at output stage");
endmodule

[bench/tb.sv]
// Self-checking testbench for triangle_unit_normal: directed and random triangles vs. exact normal.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int LAT  = FRAC + 8;
  localparam int IW   = tun_pkg::IN_W;
  localparam int OW   = tun_pkg::OUT_W;

  typedef struct packed {
    logic [IW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct packed {
    logic [OW-1:0] nx, ny, nz;
    logic          degen;
  } normal_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, out_degenerate;
  logic [OW-1:0] out_nx, out_ny, out_nz;
  tri_t cur = '0;

  tri_t    tri_q[$];
  normal_t normal_q[$];
  int      idle_pct = 0;
  int      errors = 0;

  triangle_unit_normal dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(cur.ax), .in_ay(cur.ay), .in_az(cur.az),
    .in_bx(cur.bx), .in_by(cur.by), .in_bz(cur.bz),
    .in_cx(cur.cx), .in_cy(cur.cy), .in_cz(cur.cz),
    .out_valid(out_valid), .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate)
  );

  initial forever #4 clk = ~clk;

  // exact normalized cross product, halves rounded away from zero
  function automatic normal_t unit_normal(tri_t t);
    longint    ux, uy, uz, vx, vy, vz;
    longint    n[3];
    bit [127:0] mag[3];
    bit [127:0] sum, rhs, d;
    longint    lo, hi, mid;
    logic [OW-1:0] q[3];
    normal_t   r;
    ux = longint'($signed(t.bx)) - longint'($signed(t.ax));
    uy = longint'($signed(t.by)) - longint'($signed(t.ay));
    uz = longint'($signed(t.bz)) - longint'($signed(t.az));
    vx = longint'($signed(t.cx)) - longint'($signed(t.bx));
    vy = longint'($signed(t.cy)) - longint'($signed(t.by));
    vz = longint'($signed(t.cz)) - longint'($signed(t.bz));
    n[0] = uy * vz - uz * vy;
    n[1] = uz * vx - ux * vz;
    n[2] = ux * vy - uy * vx;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (n[i] < 0) ? 128'(-n[i]) : 128'(n[i]);
      sum += mag[i] * mag[i];
    end
    if (sum == 0) begin
      r = '0;
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      rhs = (mag[i] * mag[i]) << (2 * FRAC + 2);
      lo = 0;
      hi = longint'(1) << FRAC;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d = 128'(2 * mid - 1);
        if (d * d * sum <= rhs) lo = mid;
        else hi = mid - 1;
      end
      q[i] = (n[i] < 0) ? OW'(-lo) : OW'(lo);
    end
    r.nx = q[0];
    r.ny = q[1];
    r.nz = q[2];
    r.degen = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) normal_q.push_back(unit_normal(cur));
      if (!start || !busy) begin
        if (tri_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          cur   <= tri_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_t got, want;
    if (rst_n && out_valid) begin
      got = {out_nx, out_ny, out_nz, out_degenerate};
      if (normal_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = normal_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp nx=%h ny=%h nz=%h dg=%b  got nx=%h ny=%h nz=%h dg=%b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  function automatic tri_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                              int c0, int c1, int c2);
    tri_t t;
    t = {16'(a0), 16'(a1), 16'(a2), 16'(b0), 16'(b1), 16'(b2),
         16'(c0), 16'(c1), 16'(c2)};
    return t;
  endfunction

  function automatic logic [15:0] rnd_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    int   span, kind, k;
    kind = $urandom_range(9);
    span = (kind < 5) ? 0 : (kind < 8) ? 20 : 3;
    t = {rnd_coord(span), rnd_coord(span), rnd_coord(span),
         rnd_coord(span), rnd_coord(span), rnd_coord(span),
         rnd_coord(span), rnd_coord(span), rnd_coord(span)};
    if (kind == 9) begin
      // collinear: C = B + k*(B - A)
      k = $urandom_range(4) - 2;
      t.cx = t.bx + 16'(k) * (t.bx - t.ax);
      t.cy = t.by + 16'(k) * (t.by - t.ay);
      t.cz = t.bz + 16'(k) * (t.bz - t.az);
    end
    return t;
  endfunction

  initial begin
    int pct[4];
    pct = '{0, 59, 0, 24};
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    tri_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    tri_q.push_back(mk(0, 0, 0, 1, 0, 0, 1, 1, 0));
    tri_q.push_back(mk(0, 0, 0, 0, 1, 0, 0, 1, 1));
    tri_q.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, 1));
    tri_q.push_back(mk(0, 0, 0, 1, 0, 0, 1, -1, 0));
    tri_q.push_back(mk(0, 0, 0, 1, 1, 1, 2, 2, 2));
    tri_q.push_back(mk(5, 5, 5, 5, 5, 5, 9, 9, 9));
    tri_q.push_back(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                       32767, 32767, -32768));
    tri_q.push_back(mk(32767, 32767, 32767, -32768, 32767, 32767,
                       -32768, -32768, 32767));
    tri_q.push_back(mk(-32768, 32767, -32768, 32767, -32768, 32767,
                       -32768, -32768, 32767));
    tri_q.push_back(mk(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767));
    tri_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                       -32768, -32768, -32768));
    tri_q.push_back(mk(0, 0, 0, 3, 0, 0, 3, 4, 0));
    tri_q.push_back(mk(0, 0, 0, 1, 0, 0, 1, 1, 1));
    tri_q.push_back(mk(1, 2, 3, 4, 6, 8, -2, 7, 1));
    tri_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p];
      for (int i = 0; i < 250; i++) tri_q.push_back(rnd_tri());
      wait (tri_q.size() == 0);
    end
    @(posedge clk);
    while (start || normal_q.size() > 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
